[rtl/svm_pkg.sv]
// Shared types and constants for the sample voice mixer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package svm_pkg;

  // Operand and product widths of the shared multiplier
  localparam int MUL_W  = 18;
  localparam int PROD_W = 2 * MUL_W;

  // Item mode codes
  localparam logic [2:0] MODE_LOAD   = 3'd0;
  localparam logic [2:0] MODE_PLAY   = 3'd1;
  localparam logic [2:0] MODE_STOP   = 3'd2;
  localparam logic [2:0] MODE_VOLUME = 3'd3;
  localparam logic [2:0] MODE_PAN    = 3'd4;
  localparam logic [2:0] MODE_LOOPS  = 3'd5;
  localparam logic [2:0] MODE_TICK   = 3'd6;

  localparam logic [16:0] UNITY_Q15  = 17'd32768;
  localparam logic [12:0] MAX_REGION = 13'd4096;
  localparam int          MIX_MAX    = 524287;
  localparam int          MIX_MIN    = -524288;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD_Q,
    ST_MOD_R,
    ST_APPLY,
    ST_VOICE,
    ST_GAIN_L,
    ST_GAIN_R,
    ST_MUL_L,
    ST_MUL_R,
    ST_DONE
  } svm_state_e;

endpackage

`default_nettype wire

[rtl/svm_mul.sv]
// Shared signed 18x18 multiplier with a registered product.
// Depends on svm_pkg for operand widths.
`timescale 1ns / 1ps
`default_nettype none

module svm_mul (
  input  wire logic                               clk_i,
  input  wire logic signed [svm_pkg::MUL_W-1:0]   a_i,
  input  wire logic signed [svm_pkg::MUL_W-1:0]   b_i,
  output logic signed      [svm_pkg::PROD_W-1:0]  prod_o
);
  import svm_pkg::*;

  always_ff @(posedge clk_i) begin
    prod_o <= a_i * b_i;
  end

endmodule

`default_nettype wire

[rtl/sample_voice_mixer.sv]
// Multi-voice mono sample player and stereo mixer, top level.
// Depends on svm_pkg and svm_mul.
//
// Items are taken on start while busy is low. A load or play item steps through
// ST_MOD_Q, ST_MOD_R and ST_APPLY (address wrap goes through the shared multiplier in
// two steps); stop, volume, pan and loops go to ST_APPLY; an unknown mode leaves the
// block idle. A tick visits ST_VOICE for each voice, and each sounding voice also passes
// ST_GAIN_L, ST_GAIN_R, ST_MUL_L and ST_MUL_R: it needs four products from the single
// 18x18 multiplier (left gain, right gain, left and right contribution). The tick result
// appears on left_mix_o, right_mix_o and released_mask_o for exactly one cycle with
// done_o high; it cannot be held off and must be taken in that cycle. Sample words that
// were never loaded read as undefined.
`timescale 1ns / 1ps
`default_nettype none

module sample_voice_mixer #(
  parameter int VOICES       = 8,
  parameter int SAMPLE_WORDS = 4096,
  parameter int SAMPLE_BITS  = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         mode_i,
  input  wire logic [2:0]         voice_i,
  input  wire logic [11:0]        address_i,
  input  wire logic [12:0]        length_i,
  input  wire logic signed [15:0] sample_in_i,
  input  wire logic [15:0]        volume_in_i,
  input  wire logic signed [15:0] pan_in_i,
  input  wire logic [15:0]        loops_in_i,
  output logic                    done_o,
  output logic signed [19:0]      left_mix_o,
  output logic signed [19:0]      right_mix_o,
  output logic [7:0]              released_mask_o
);
  import svm_pkg::*;

  localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int AW     = $clog2(SAMPLE_WORDS);
  localparam int MEM_W  = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;
  localparam int SUM_W  = (17 + $clog2(VOICES) > 21) ? 17 + $clog2(VOICES) : 21;
  localparam int XW     = (AW > 12) ? AW : 12;
  localparam bit WRAP   = SAMPLE_WORDS < 4096;
  localparam int RED_S  = 12 + AW;
  localparam longint unsigned RED_R =
    WRAP ? (((64'd1 << RED_S) + SAMPLE_WORDS - 1) / SAMPLE_WORDS) : 64'd0;

  svm_state_e state_q, state_d;

  // captured item
  logic [2:0]         mode_q;
  logic [2:0]         voice_q;
  logic [11:0]        addr_q;
  logic [12:0]        len_q;
  logic [15:0]        sample_q;
  logic [15:0]        vol_in_q;
  logic [15:0]        pan_in_q;
  logic [15:0]        loops_in_q;

  // voice state
  logic               act_q   [VOICES];
  logic [AW-1:0]      vstart_q[VOICES];
  logic [AW-1:0]      vidx_q  [VOICES];
  logic [12:0]        vlen_q  [VOICES];
  logic [11:0]        vpos_q  [VOICES];
  logic [15:0]        vloop_q [VOICES];
  logic [15:0]        vvol_q  [VOICES];
  logic signed [15:0] vpan_q  [VOICES];

  logic [MEM_W-1:0]   sample_mem[SAMPLE_WORDS];
  logic [MEM_W-1:0]   rd_q;

  logic [VIDX_W-1:0]  cnt_q;
  logic [16:0]        gl_q, gr_q;
  logic signed [SUM_W-1:0] acc_l_q, acc_r_q;
  logic [7:0]         mask_q;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_q;

  logic               accept;
  logic [VIDX_W-1:0]  ev;
  logic               ev_ok;
  logic               sounding, last;
  logic [XW-1:0]      red_diff;
  logic [AW-1:0]      red;
  logic signed [15:0] samp;
  logic signed [15:0] pan_k;
  logic signed [17:0] term_l_full, term_r_full;
  logic [16:0]        term_l, term_r;
  logic [16:0]        gain_new;
  logic signed [15:0] contrib;
  logic [12:0]        pos_next;
  logic               region_end;
  logic               free_en;
  logic [2:0]         mask_idx;

  assign accept   = start && !busy;
  assign ev       = VIDX_W'(voice_q);
  assign ev_ok    = 32'(voice_q) < VOICES;
  assign sounding = act_q[cnt_q] && (vloop_q[cnt_q] != '0) && (vlen_q[cnt_q] != '0);
  assign last     = cnt_q == VIDX_W'(VOICES - 1);
  assign red_diff = XW'(addr_q) - prod_q[XW-1:0];
  assign red      = red_diff[AW-1:0];
  assign mask_idx = 3'(cnt_q);

  always_comb begin
    samp = '0;
    samp[15 -: MEM_W] = rd_q;
  end

  // side gain terms, sat(1 - pan) and sat(1 + pan)
  assign pan_k       = vpan_q[cnt_q];
  assign term_l_full = 18'sd32768 - 18'(pan_k);
  assign term_r_full = 18'sd32768 + 18'(pan_k);
  assign term_l      = pan_k[15] || (pan_k == '0) ? UNITY_Q15 : term_l_full[16:0];
  assign term_r      = !pan_k[15] ? UNITY_Q15 : term_r_full[16:0];
  assign gain_new    = (prod_q[35:15] > 21'd32768) ? UNITY_Q15 : prod_q[31:15];
  assign contrib     = prod_q[30:15];

  assign pos_next   = 13'(vpos_q[cnt_q]) + 13'd1;
  assign region_end = pos_next >= vlen_q[cnt_q];
  assign free_en    = ((state_q == ST_VOICE) && act_q[cnt_q] && !sounding) ||
                      ((state_q == ST_MUL_R) && region_end && (vloop_q[cnt_q] == 16'd1));

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        cnt_q <= '0;
      end else if ((state_q == ST_VOICE && !sounding) || state_q == ST_MUL_R) begin
        if (!last) begin
          cnt_q <= cnt_q + VIDX_W'(1);
        end
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (mode_i)
            MODE_LOAD, MODE_PLAY: state_d = ST_MOD_Q;
            MODE_STOP, MODE_VOLUME, MODE_PAN, MODE_LOOPS: state_d = ST_APPLY;
            MODE_TICK: state_d = ST_VOICE;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_MOD_Q:  state_d = ST_MOD_R;
      ST_MOD_R:  state_d = ST_APPLY;
      ST_APPLY:  state_d = ST_IDLE;
      ST_VOICE: begin
        if (sounding) begin
          state_d = ST_GAIN_L;
        end else if (last) begin
          state_d = ST_DONE;
        end
      end
      ST_GAIN_L: state_d = ST_GAIN_R;
      ST_GAIN_R: state_d = ST_MUL_L;
      ST_MUL_L:  state_d = ST_MUL_R;
      ST_MUL_R:  state_d = last ? ST_DONE : ST_VOICE;
      ST_DONE:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_MOD_Q: begin
        mul_a = MUL_W'(addr_q);
        mul_b = MUL_W'(RED_R);
      end
      ST_MOD_R: begin
        mul_a = MUL_W'($unsigned(prod_q) >> RED_S);
        mul_b = MUL_W'(SAMPLE_WORDS);
      end
      ST_VOICE: begin
        mul_a = {2'b00, vvol_q[cnt_q]};
        mul_b = {1'b0, term_l};
      end
      ST_GAIN_L: begin
        mul_a = {2'b00, vvol_q[cnt_q]};
        mul_b = {1'b0, term_r};
      end
      ST_GAIN_R: begin
        mul_a = MUL_W'(samp);
        mul_b = {1'b0, gl_q};
      end
      ST_MUL_L: begin
        mul_a = MUL_W'(samp);
        mul_b = {1'b0, gr_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  svm_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod_q)
  );

  // item capture and mix datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q     <= mode_i;
      voice_q    <= voice_i;
      addr_q     <= address_i;
      len_q      <= length_i;
      sample_q   <= sample_in_i;
      vol_in_q   <= volume_in_i;
      pan_in_q   <= pan_in_i;
      loops_in_q <= loops_in_i;
      acc_l_q    <= '0;
      acc_r_q    <= '0;
      mask_q     <= '0;
    end else begin
      if (state_q == ST_GAIN_L) gl_q <= gain_new;
      if (state_q == ST_GAIN_R) gr_q <= gain_new;
      if (state_q == ST_MUL_L)  acc_l_q <= acc_l_q + SUM_W'(contrib);
      if (state_q == ST_MUL_R)  acc_r_q <= acc_r_q + SUM_W'(contrib);
      if (free_en && (32'(cnt_q) < 8)) mask_q[mask_idx] <= 1'b1;
    end
  end

  // sample memory
  always_ff @(posedge clk_i) begin
    if (state_q == ST_APPLY && mode_q == MODE_LOAD) begin
      sample_mem[red] <= sample_q[15 -: MEM_W];
    end
    if (state_q == ST_VOICE) begin
      rd_q <= sample_mem[vidx_q[cnt_q]];
    end
  end

  // voice state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < VOICES; i++) begin
        act_q[i]    <= 1'b0;
        vstart_q[i] <= '0;
        vidx_q[i]   <= '0;
        vlen_q[i]   <= '0;
        vpos_q[i]   <= '0;
        vloop_q[i]  <= '0;
        vvol_q[i]   <= 16'd32768;
        vpan_q[i]   <= '0;
      end
    end else begin
      if (state_q == ST_APPLY && ev_ok) begin
        case (mode_q)
          MODE_PLAY: begin
            act_q[ev]    <= 1'b1;
            vstart_q[ev] <= red;
            vidx_q[ev]   <= red;
            vlen_q[ev]   <= (len_q > MAX_REGION) ? MAX_REGION : len_q;
            vpos_q[ev]   <= '0;
            vloop_q[ev]  <= '0;
            vvol_q[ev]   <= 16'd32768;
            vpan_q[ev]   <= '0;
          end
          MODE_STOP:   if (act_q[ev]) vloop_q[ev] <= '0;
          MODE_VOLUME: if (act_q[ev]) vvol_q[ev]  <= vol_in_q;
          MODE_PAN:    if (act_q[ev]) vpan_q[ev]  <= pan_in_q;
          MODE_LOOPS:  if (act_q[ev]) vloop_q[ev] <= loops_in_q;
          default: begin
          end
        endcase
      end
      if (state_q == ST_VOICE && act_q[cnt_q] && !sounding) begin
        vloop_q[cnt_q] <= '0;
      end
      if (state_q == ST_MUL_R) begin
        if (region_end) begin
          vpos_q[cnt_q]  <= '0;
          vidx_q[cnt_q]  <= vstart_q[cnt_q];
          vloop_q[cnt_q] <= vloop_q[cnt_q] - 16'd1;
        end else begin
          vpos_q[cnt_q] <= pos_next[11:0];
          vidx_q[cnt_q] <= (vidx_q[cnt_q] == AW'(SAMPLE_WORDS - 1)) ? '0
                           : vidx_q[cnt_q] + AW'(1);
        end
      end
      if (free_en) begin
        act_q[cnt_q] <= 1'b0;
      end
    end
  end

  function automatic logic [19:0] sat_mix(input logic signed [SUM_W-1:0] v);
    logic [19:0] r;
    if (v > SUM_W'(MIX_MAX)) begin
      r = 20'(MIX_MAX);
    end else if (v < SUM_W'(MIX_MIN)) begin
      r = 20'(MIX_MIN);
    end else begin
      r = v[19:0];
    end
    return r;
  endfunction

  assign busy            = state_q != ST_IDLE;
  assign done_o          = state_q == ST_DONE;
  assign left_mix_o      = sat_mix(acc_l_q);
  assign right_mix_o     = sat_mix(acc_r_q);
  assign released_mask_o = mask_q;

endmodule

`default_nettype wire
